// ----- hdl/itrt_pkg.sv -----
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and the digit-to-character mapping of the integer to
// radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

    localparam int NUMBER_W    = 64;
    localparam int BASE_W      = 6;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int DIGIT_SLOTS = 64;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);
    localparam int COUNT_W     = SLOT_W + 1;
    localparam int STEP_W      = $clog2(NUMBER_W);

    localparam logic [BASE_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [BASE_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SIGN = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_READ = 5'b01000,
        ST_SHOW = 5'b10000
    } state_t;

    typedef struct packed {
        logic busy;
        logic digit_done;
        logic quot_zero;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10))
            glyph_of = CHAR_ZERO + ext;
        else
            glyph_of = CHAR_ALPHA + ext - CHAR_W'(10);
    endfunction

endpackage

// ----- hdl/itrt_req_if.sv -----
// ----------------------------------------------------------------------------
// itrt_req_if
// Request channel: the value to convert and its radix.
// ----------------------------------------------------------------------------
interface itrt_req_if
    import itrt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] number;
    logic [BASE_W-1:0]   base;

    modport source (output valid, output number, output base, input ready);
    modport sink   (input valid, input number, input base, output ready);
endinterface

// ----- hdl/itrt_text_if.sv -----
// ----------------------------------------------------------------------------
// itrt_text_if
// Text channel: one ASCII character per transaction, with the last flag.
// ----------------------------------------------------------------------------
interface itrt_text_if
    import itrt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- hdl/itrt_divider.sv -----
// ----------------------------------------------------------------------------
// itrt_divider
// Bit-serial restoring divider: divides the held quotient by the radix, one
// quotient bit per cycle, and yields one digit at the end of each pass.
// ----------------------------------------------------------------------------
module itrt_divider
    import itrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cont,
    input  logic [NUMBER_W-1:0] dividend,
    input  logic [BASE_W-1:0]   radix,
    output div_status_t         status,
    output logic [DIGIT_W-1:0]  digit
);

    logic [NUMBER_W-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [BASE_W-1:0]   radix_reg;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIGIT_W:0]    trial;
    logic                fits;

    assign trial = {rem_reg, quot_reg[NUMBER_W-1]};
    assign fits  = trial >= {1'b0, radix_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (cont)
        begin
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUMBER_W-2:0], fits};
            rem_next  = fits ? DIGIT_W'(trial - {1'b0, radix_reg}) : trial[DIGIT_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUMBER_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
            radix_reg <= radix;
    end

    assign status.busy       = busy_reg;
    assign status.digit_done = done_reg;
    assign status.quot_zero  = quot_reg == '0;
    assign digit             = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("digit reported while the divider is still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg == STEP_W'(NUMBER_W - 1) && !start && !cont) |=> done_reg)
        else $error("final step did not report a digit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && !cont) |=> rem_reg < radix_reg)
        else $error("partial remainder reached the radix");

endmodule

// ----- hdl/integer_to_radix_text.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts a 64-bit value to its ASCII text in radix 2 to 36, most significant
// character first, with a leading minus sign for negative decimal values.
//
//   Channel   Role    Payload                 Transaction
//   request   sink    number[63:0], base[5:0] one value to convert
//   text      source  character[7:0], last    one character of the text
//
// Each digit comes from the bit-serial divider into the digit memory; readout
// then passes each character through the READ and SHOW states.
// Reset clears the control state only; the digit memory needs no clearing.
// A stalled text channel holds the current character and pauses readout.
// ----------------------------------------------------------------------------
module integer_to_radix_text
    import itrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    itrt_req_if.sink     request,
    itrt_text_if.source  text
);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic                fin_reg;
    logic [SLOT_W-1:0]   rd_idx_reg;
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic [DIGIT_W-1:0]  digit_mem [DIGIT_SLOTS];

    logic                out_valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;

    logic                accept;
    logic [BASE_W-1:0]   radix;
    logic                negative;
    logic [NUMBER_W-1:0] magnitude;
    logic                out_free;
    logic                load_sign;
    logic                load_digit;
    logic                cont;
    div_status_t         div_stat;
    logic [DIGIT_W-1:0]  div_digit;

    assign request.ready = state_reg == ST_IDLE;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        radix = request.base;
        if (request.base < RADIX_MIN)
            radix = RADIX_MIN;
        else if (request.base > RADIX_MAX)
            radix = RADIX_MAX;
    end

    assign negative  = (radix == RADIX_DEC) && request.number[NUMBER_W-1];
    assign magnitude = negative ? (NUMBER_W'(0) - request.number) : request.number;

    assign cont = div_stat.digit_done && !div_stat.quot_zero
                  && (count_reg != COUNT_W'(DIGIT_SLOTS - 1));

    itrt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cont     (cont),
        .dividend (magnitude),
        .radix    (radix),
        .status   (div_stat),
        .digit    (div_digit)
    );

    assign out_free   = !out_valid_reg || text.ready;
    assign load_sign  = (state_reg == ST_SIGN) && out_free;
    assign load_digit = (state_reg == ST_SHOW) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = negative ? ST_SIGN : ST_DIV;
            ST_SIGN:
                if (out_free)
                    state_next = ST_DIV;
            ST_DIV:
                if (fin_reg)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_SHOW;
            ST_SHOW:
                if (out_free)
                    state_next = (rd_idx_reg == '0) ? ST_IDLE : ST_READ;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                count_reg <= '0;
                fin_reg   <= 1'b0;
            end
            else if (div_stat.digit_done)
            begin
                count_reg <= count_reg + COUNT_W'(1);
                fin_reg   <= !cont;
            end
            if (state_reg == ST_DIV && fin_reg)
                rd_idx_reg <= count_reg[SLOT_W-1:0] - SLOT_W'(1);
            else if (load_digit && rd_idx_reg != '0)
                rd_idx_reg <= rd_idx_reg - SLOT_W'(1);
            if (load_sign || load_digit)
                out_valid_reg <= 1'b1;
            else if (text.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_stat.digit_done)
            digit_mem[count_reg[SLOT_W-1:0]] <= div_digit;
        rd_data_reg <= digit_mem[rd_idx_reg];
        if (load_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (load_digit)
        begin
            char_reg <= glyph_of(rd_data_reg);
            last_reg <= rd_idx_reg == '0;
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.digit_done |-> (state_reg == ST_SIGN || state_reg == ST_DIV))
        else $error("digit arrived outside the conversion phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while a new value can be taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_SHOW)
            |-> (count_reg != '0 && COUNT_W'(rd_idx_reg) < count_reg))
        else $error("readout index outside the stored digits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load_digit && rd_idx_reg == '0) |=> (state_reg == ST_IDLE && last_reg))
        else $error("final character did not end the text");

endmodule

// ----- sim/itrt_text_checker.sv -----
// ----------------------------------------------------------------------------
// itrt_text_checker
// Watches the request and text channels of the integer to radix text
// converter. It predicts the characters of every accepted request and compares
// each accepted text transaction with the oldest expected character.
// ----------------------------------------------------------------------------
module itrt_text_checker
    import itrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    itrt_req_if   request,
    itrt_text_if  text,
    output int    fail_count,
    output int    pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    text_char_t expected_text [$];

    function automatic void predict_text(input logic [NUMBER_W-1:0] num,
                                         input logic [BASE_W-1:0]   b);
        logic [NUMBER_W-1:0] quotient;
        logic [NUMBER_W-1:0] radix;
        logic [DIGIT_W-1:0]  digits [DIGIT_SLOTS];
        logic [CHAR_W-1:0]   ch;
        int                  count;
        int                  i;
        if (b < RADIX_MIN)
            radix = NUMBER_W'(RADIX_MIN);
        else if (b > RADIX_MAX)
            radix = NUMBER_W'(RADIX_MAX);
        else
            radix = NUMBER_W'(b);
        quotient = num;
        if (radix == NUMBER_W'(RADIX_DEC) && num[NUMBER_W-1])
        begin
            expected_text.push_back('{character: CHAR_MINUS, last: 1'b0});
            quotient = -num;
        end
        count = 0;
        do
        begin
            digits[count] = DIGIT_W'(quotient % radix);
            count++;
            quotient = quotient / radix;
        end
        while (quotient != 0 && count < DIGIT_SLOTS);
        for (i = count - 1; i >= 0; i--)
        begin
            if (digits[i] < DIGIT_W'(10))
                ch = CHAR_ZERO + CHAR_W'(digits[i]);
            else
                ch = CHAR_ALPHA + CHAR_W'(digits[i]) - CHAR_W'(10);
            expected_text.push_back('{character: ch, last: (i == 0)});
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        text_char_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
                predict_text(request.number, request.base);
            if (text.valid && text.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected text transaction: expected none, actual %h last %b",
                             $time, text.character, text.last);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text.character !== want.character)
                    begin
                        fail_count++;
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, want.character, text.character);
                    end
                    if (text.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, text.last);
                    end
                end
            end
            pending = expected_text.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Top of the integer to radix text converter testbench. It drives directed and
// random conversion requests under varying idle patterns on both channels,
// including one long stall of the text channel, and reports the verdict from
// the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;

    import itrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 146;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 6000000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   pressure_req;
    bit   pressure_taken;

    itrt_req_if  request_ch ();
    itrt_text_if text_ch ();

    integer_to_radix_text DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .text    (text_ch)
    );

    itrt_text_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request_ch),
        .text       (text_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** integer_to_radix_text: FAILED **");
        $finish;
    end

    initial
    begin : text_sink
        int hold_left;
        hold_left = 0;
        pressure_taken = 1'b0;
        text_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_req && !pressure_taken)
            begin
                pressure_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                text_ch.ready <= 1'b0;
            end
            else
                text_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic offer(input logic [NUMBER_W-1:0] num, input logic [BASE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid  <= 1'b1;
        request_ch.number <= num;
        request_ch.base   <= b;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
    endtask

    task automatic offer_random();
        logic [NUMBER_W-1:0] num;
        logic [NUMBER_W-1:0] power;
        logic [BASE_W-1:0]   b;
        int                  kind;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15)
            b = BASE_W'($urandom_range(0, 63));
        else
            b = BASE_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        if (kind < 40)
            num = {$urandom(), $urandom()};
        else if (kind < 65)
            num = NUMBER_W'($urandom_range(0, 65535));
        else if (kind < 80)
            num = -NUMBER_W'($urandom_range(1, 100000));
        else
        begin
            b = BASE_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            power = 1;
            repeat ($urandom_range(1, 14))
                power = power * NUMBER_W'(b);
            num = power - NUMBER_W'($urandom_range(0, 1));
        end
        offer(num, b);
    endtask

    initial
    begin : stimulus
        rst_n            = 1'b0;
        pressure_req     = 1'b0;
        send_idle_pct    = 10;
        recv_idle_pct    = 76;
        request_ch.valid  <= 1'b0;
        request_ch.number <= '0;
        request_ch.base   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values: extremes, saturated radixes, letters, zero and the
        // most negative decimal value.
        offer(64'd0, 6'd10);
        offer(64'd0, 6'd2);
        offer(64'd1, 6'd2);
        offer(-64'd1, 6'd10);
        offer(-64'd1, 6'd2);
        offer(-64'd1, 6'd16);
        offer(-64'd1, 6'd36);
        offer(64'h8000_0000_0000_0000, 6'd10);
        offer(64'h8000_0000_0000_0000, 6'd2);
        offer(64'h7FFF_FFFF_FFFF_FFFF, 6'd10);
        offer(64'h7FFF_FFFF_FFFF_FFFF, 6'd36);
        offer(64'd35, 6'd36);
        offer(64'd36, 6'd36);
        offer(64'd255, 6'd16);
        offer(-64'd12345, 6'd10);
        offer(64'd12345, 6'd8);
        offer(64'd5, 6'd0);
        offer(64'd5, 6'd1);
        offer(64'd100, 6'd37);
        offer(64'd100, 6'd63);
        offer(64'd9, 6'd10);
        offer(64'd10, 6'd11);
        offer(-64'd1, 6'd0);
        offer(64'd1000, 6'd3);

        repeat (RANDOM_ITEMS / 3)
            offer_random();

        send_idle_pct = 76;
        recv_idle_pct = 10;
        repeat (RANDOM_ITEMS / 3)
            offer_random();

        // The text channel stalls for a long stretch while requests keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_req  = 1'b1;
        repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3))
            offer_random();
        request_ch.valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("** integer_to_radix_text: PASSED **");
        else
            $display("** integer_to_radix_text: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/itrt_pkg.sv
hdl/itrt_req_if.sv
hdl/itrt_text_if.sv
hdl/itrt_divider.sv
hdl/integer_to_radix_text.sv
sim/itrt_text_checker.sv
sim/tb.sv
